// ===== rtl/ccsd_pkg.sv =====
// Shared types and constants for the crank/cam sync decoder.
`default_nettype none

package ccsd_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_PRIMARY_RISING   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SECONDARY_RISING = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_PULSE_WIDTH  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_ADVANCE      = 2'd3;

  // Request type codes
  localparam logic REQ_PRIMARY   = 1'b0;
  localparam logic REQ_SECONDARY = 1'b1;

  localparam logic [15:0] ADVANCE_LIMIT_MAX = 16'hFFFF;
  localparam logic [7:0]  CHANNEL_MAX       = 8'd5;

  typedef struct packed {
    logic        primary_rising;
    logic        secondary_rising;
    logic [15:0] min_pulse_width;
    logic [15:0] min_advance;
  } cfg_t;

  typedef struct packed {
    logic        req_type;
    logic        pin_level;
    logic [15:0] edge_time;
    logic [15:0] ext_clock;
    logic        overflow_pending;
    logic [15:0] master_pulse_width;
    logic [15:0] injection_angle;
  } in_req_t;

  typedef struct packed {
    logic        in_sync;
    logic [7:0]  tooth_count;
    logic [7:0]  teeth_last_rev;
    logic        sample_request;
    logic        schedule_valid;
    logic [2:0]  channel;
    logic [15:0] start_time;
    logic [31:0] start_time_long;
    logic [31:0] cycle_period;
    logic [15:0] tooth_period;
    logic [15:0] sync_losses;
    logic [15:0] dropped_teeth;
  } out_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/ccsd_cfg.sv =====
// Configuration register file for the crank/cam sync decoder.
`default_nettype none

module ccsd_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            wr_en,
  input  wire logic [ccsd_pkg::CFG_INDEX_W-1:0] wr_index,
  input  wire logic [ccsd_pkg::CFG_DATA_W-1:0]  wr_data,
  output ccsd_pkg::cfg_t                       cfg
);
  import ccsd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.primary_rising   <= 1'b1;
      cfg.secondary_rising <= 1'b1;
      cfg.min_pulse_width  <= '0;
      cfg.min_advance      <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_PRIMARY_RISING:   cfg.primary_rising   <= wr_data[0];
        CFG_SECONDARY_RISING: cfg.secondary_rising <= wr_data[0];
        CFG_MIN_PULSE_WIDTH:  cfg.min_pulse_width  <= wr_data;
        CFG_MIN_ADVANCE:      cfg.min_advance      <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ccsd_core.sv =====
// Decoder state registers and the single-pass edge event logic.
`default_nettype none

module ccsd_core #(
  parameter int TEETH_PER_CAM = 12
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ccsd_pkg::cfg_t     cfg,
  input  wire logic               fire,
  input  wire ccsd_pkg::in_req_t  req,
  output ccsd_pkg::out_rsp_t      rsp
);
  import ccsd_pkg::*;

  localparam logic [7:0] TEETH_LIMIT = 8'(TEETH_PER_CAM);

  logic [7:0]  tooth_counter,    tooth_counter_next;
  logic        sync_flag,        sync_flag_next;
  logic [7:0]  latched_teeth,    latched_teeth_next;
  logic [15:0] last_tooth_stamp, last_tooth_stamp_next;
  logic [15:0] smoothed_period,  smoothed_period_next;
  logic [31:0] last_cam_stamp,   last_cam_stamp_next;
  logic [31:0] engine_period,    engine_period_next;
  logic [15:0] loss_counter,     loss_counter_next;
  logic [15:0] drop_counter,     drop_counter_next;

  logic        active;
  logic [15:0] stamp_hi;
  logic [31:0] stamp;
  logic [7:0]  tooth_inc;
  logic [15:0] interval;
  logic [15:0] adv_limit;
  logic [15:0] advance;
  logic [7:0]  chan_wide;
  logic [31:0] cam_delta;
  logic        sample;
  logic        sched;

  always_comb begin
    if (req.req_type == REQ_SECONDARY) begin
      active = cfg.secondary_rising ? req.pin_level : !req.pin_level;
    end else begin
      active = cfg.primary_rising ? req.pin_level : !req.pin_level;
    end
    // bump the high word when a pending overflow predates this capture
    stamp_hi = (req.overflow_pending && !req.edge_time[15]) ?
               req.ext_clock + 16'd1 : req.ext_clock;
    stamp     = {stamp_hi, req.edge_time};
    tooth_inc = tooth_counter + 8'd1;
    interval  = req.edge_time - last_tooth_stamp;
    cam_delta = stamp - last_cam_stamp;
    adv_limit = (engine_period[31:17] != '0) ? ADVANCE_LIMIT_MAX : engine_period[16:1];
    if (req.injection_angle > adv_limit) begin
      advance = adv_limit;
    end else if (req.injection_angle < cfg.min_advance) begin
      advance = cfg.min_advance;
    end else begin
      advance = req.injection_angle;
    end
    chan_wide = {1'b0, tooth_inc[7:1]} - 8'd1;
  end

  always_comb begin
    tooth_counter_next    = tooth_counter;
    sync_flag_next        = sync_flag;
    latched_teeth_next    = latched_teeth;
    last_tooth_stamp_next = last_tooth_stamp;
    smoothed_period_next  = smoothed_period;
    last_cam_stamp_next   = last_cam_stamp;
    engine_period_next    = engine_period;
    loss_counter_next     = loss_counter;
    drop_counter_next     = drop_counter;
    sample                = 1'b0;
    sched                 = 1'b0;

    if (active) begin
      if (req.req_type == REQ_SECONDARY) begin
        latched_teeth_next = tooth_counter;
        tooth_counter_next = '0;
        if (tooth_counter != TEETH_LIMIT && sync_flag) begin
          loss_counter_next = loss_counter + 16'd1;
        end
        engine_period_next  = {cam_delta[30:0], 1'b0};
        last_cam_stamp_next = stamp;
        sync_flag_next      = 1'b1;
      end else begin
        tooth_counter_next = tooth_inc;
        if (!sync_flag) begin
          drop_counter_next = drop_counter + 16'd1;
        end else begin
          last_tooth_stamp_next = req.edge_time;
          smoothed_period_next  = {1'b0, interval[15:1]} + {1'b0, smoothed_period[15:1]};
          if (tooth_inc > TEETH_LIMIT) begin
            // too many teeth: drop sync and restart the count
            loss_counter_next  = loss_counter + 16'd1;
            sync_flag_next     = 1'b0;
            tooth_counter_next = '0;
          end else if (!tooth_inc[0]) begin
            sample = 1'b1;
            sched  = (req.master_pulse_width > cfg.min_pulse_width) &&
                     (chan_wide <= CHANNEL_MAX);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tooth_counter    <= '0;
      sync_flag        <= 1'b0;
      latched_teeth    <= '0;
      last_tooth_stamp <= '0;
      smoothed_period  <= '0;
      last_cam_stamp   <= '0;
      engine_period    <= '0;
      loss_counter     <= '0;
      drop_counter     <= '0;
    end else if (fire) begin
      tooth_counter    <= tooth_counter_next;
      sync_flag        <= sync_flag_next;
      latched_teeth    <= latched_teeth_next;
      last_tooth_stamp <= last_tooth_stamp_next;
      smoothed_period  <= smoothed_period_next;
      last_cam_stamp   <= last_cam_stamp_next;
      engine_period    <= engine_period_next;
      loss_counter     <= loss_counter_next;
      drop_counter     <= drop_counter_next;
    end
  end

  always_comb begin
    rsp.in_sync         = sync_flag_next;
    rsp.tooth_count     = tooth_counter_next;
    rsp.teeth_last_rev  = latched_teeth_next;
    rsp.sample_request  = sample;
    rsp.schedule_valid  = sched;
    rsp.channel         = sched ? chan_wide[2:0] : 3'd0;
    rsp.start_time      = sched ? req.edge_time + advance : 16'd0;
    rsp.start_time_long = sched ? stamp + {16'd0, advance} : 32'd0;
    rsp.cycle_period    = engine_period_next;
    rsp.tooth_period    = smoothed_period_next;
    rsp.sync_losses     = loss_counter_next;
    rsp.dropped_teeth   = drop_counter_next;
  end

endmodule

`default_nettype wire

// ===== rtl/crank_cam_sync_decoder.sv =====
// Top level of the crank/cam sync decoder: request and result registers around the core.
//
//  port group  direction  handshake            payload
//  in_*        request    in_valid / in_stall    in_data  (ccsd_pkg::in_req_t)
//  out_*       result     out_valid / out_stall  out_data (ccsd_pkg::out_rsp_t)
//  cfg_*       config     cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One edge event per cycle while the result side does not stall; a taken request
// passes through the request register, then the result register, before its
// result is offered.
// The decoder state updates as a request leaves the request register, so the
// next request sees it with no gap. A stalled result holds in the result
// register while one more request waits in the request register.
// rst is synchronous; config returns to both polarities rising, minimums zero.
`default_nettype none

module crank_cam_sync_decoder #(
  parameter int TEETH_PER_CAM = 12
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire ccsd_pkg::in_req_t                in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output ccsd_pkg::out_rsp_t                    out_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [ccsd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [ccsd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ccsd_pkg::*;

  cfg_t     cfg;
  in_req_t  req_q;
  logic     req_valid;
  logic     advance;
  logic     take;
  out_rsp_t rsp;

  assign cfg_ready = 1'b1;

  ccsd_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // move the held request into the result register when it is free
  assign advance  = req_valid && (!out_valid || !out_stall);
  assign in_stall = req_valid && !advance;
  assign take     = in_valid && !in_stall;

  ccsd_core #(
    .TEETH_PER_CAM (TEETH_PER_CAM)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .fire (advance),
    .req  (req_q),
    .rsp  (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (take) begin
      req_valid <= 1'b1;
    end else if (advance) begin
      req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      req_q <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= rsp;
    end
  end

  a_stall_needs_held_request: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> req_valid)
    else $error("request stalled with an empty request register");

  a_advance_fills_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("result register not loaded after advance");

  a_schedule_implies_sample: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.schedule_valid) |->
      (out_data.sample_request && out_data.in_sync))
    else $error("schedule issued without sample request or sync");

  a_schedule_channel_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.schedule_valid) |-> (out_data.channel <= CHANNEL_MAX[2:0]))
    else $error("scheduled channel out of range");

endmodule

`default_nettype wire

// ===== test/tb_crank_cam_sync_decoder.sv =====
// Testbench for the crank/cam sync decoder: directed and random edge streams checked against a local model.
`default_nettype none

module tb_crank_cam_sync_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import ccsd_pkg::*;

  localparam int TEETH = 12;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic      in_valid = 1'b0;
  logic      in_stall;
  in_req_t   in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_rsp_t  out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_PRIMARY_RISING;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  crank_cam_sync_decoder #(.TEETH_PER_CAM(TEETH)) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Decoder model state and its copy of the config
  cfg_t        cfg_m;
  logic [7:0]  m_teeth;
  logic        m_sync;
  logic [7:0]  m_latched;
  logic [15:0] m_last_tooth;
  logic [15:0] m_smooth;
  logic [31:0] m_last_cam;
  logic [31:0] m_period;
  logic [15:0] m_losses;
  logic [15:0] m_drops;

  in_req_t  edge_q[$];
  out_rsp_t decoded_q[$];
  out_rsp_t oldest;

  int   events_queued = 0;
  int   active_queued = 0;
  int   results_seen = 0;
  int   errors = 0;
  int   send_gap = 0;
  int   stall_left = 0;
  int   hold_left = 0;
  logic held_once = 1'b0;
  logic quiet = 1'b0;
  logic [31:0] now_ticks;

  function automatic out_rsp_t decode_edge(input in_req_t r);
    out_rsp_t    o;
    logic        active;
    logic [15:0] hi;
    logic [31:0] stamp;
    logic [15:0] interval;
    logic [15:0] limit;
    logic [15:0] adv;
    logic [7:0]  ch;
    o = '0;
    if (r.req_type == REQ_SECONDARY)
      active = cfg_m.secondary_rising ? r.pin_level : !r.pin_level;
    else
      active = cfg_m.primary_rising ? r.pin_level : !r.pin_level;
    hi = (r.overflow_pending && !r.edge_time[15]) ? r.ext_clock + 16'd1 : r.ext_clock;
    stamp = {hi, r.edge_time};
    if (active && r.req_type == REQ_SECONDARY) begin
      m_latched = m_teeth;
      m_teeth = 8'd0;
      if (m_latched != TEETH && m_sync)
        m_losses = m_losses + 16'd1;
      m_period = (stamp - m_last_cam) << 1;
      m_last_cam = stamp;
      m_sync = 1'b1;
    end else if (active) begin
      m_teeth = m_teeth + 8'd1;
      if (!m_sync) begin
        m_drops = m_drops + 16'd1;
      end else begin
        interval = r.edge_time - m_last_tooth;
        m_last_tooth = r.edge_time;
        m_smooth = (interval >> 1) + (m_smooth >> 1);
        if (m_teeth > TEETH) begin
          // too many teeth: drop sync and start over
          m_losses = m_losses + 16'd1;
          m_sync = 1'b0;
          m_teeth = 8'd0;
        end else if (!m_teeth[0]) begin
          o.sample_request = 1'b1;
          if (r.master_pulse_width > cfg_m.min_pulse_width) begin
            limit = (m_period[31:17] != 15'd0) ? ADVANCE_LIMIT_MAX : m_period[16:1];
            if (r.injection_angle > limit)
              adv = limit;
            else if (r.injection_angle < cfg_m.min_advance)
              adv = cfg_m.min_advance;
            else
              adv = r.injection_angle;
            ch = (m_teeth >> 1) - 8'd1;
            if (ch <= CHANNEL_MAX) begin
              o.schedule_valid = 1'b1;
              o.channel = ch[2:0];
              o.start_time = r.edge_time + adv;
              o.start_time_long = stamp + {16'd0, adv};
            end
          end
        end
      end
    end
    o.in_sync = m_sync;
    o.tooth_count = m_teeth;
    o.teeth_last_rev = m_latched;
    o.cycle_period = m_period;
    o.tooth_period = m_smooth;
    o.sync_losses = m_losses;
    o.dropped_teeth = m_drops;
    return o;
  endfunction

  task automatic compare_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      if (errors < 200)
        $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, fname, want, got);
      errors++;
    end
  endtask

  // Sender: predict on every accepted request, then offer the next one
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        decoded_q.push_back(decode_edge(in_data));
      if (!in_valid || !in_stall) begin
        if (send_gap == 0 && !quiet && $urandom_range(0, 7) == 0)
          send_gap = $urandom_range(1, 15);
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (edge_q.size() != 0) begin
          in_data <= edge_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check results in order, stall in bursts, and hold off once for long
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (decoded_q.size() == 0) begin
          if (errors < 200)
            $display("%0t ns: unexpected result, expected none, actual 0x%0h", $time, out_data);
          errors++;
        end else begin
          oldest = decoded_q.pop_front();
          compare_field("in_sync", oldest.in_sync, out_data.in_sync);
          compare_field("tooth_count", oldest.tooth_count, out_data.tooth_count);
          compare_field("teeth_last_rev", oldest.teeth_last_rev, out_data.teeth_last_rev);
          compare_field("sample_request", oldest.sample_request, out_data.sample_request);
          compare_field("schedule_valid", oldest.schedule_valid, out_data.schedule_valid);
          compare_field("channel", oldest.channel, out_data.channel);
          compare_field("start_time", oldest.start_time, out_data.start_time);
          compare_field("start_time_long", oldest.start_time_long, out_data.start_time_long);
          compare_field("cycle_period", oldest.cycle_period, out_data.cycle_period);
          compare_field("tooth_period", oldest.tooth_period, out_data.tooth_period);
          compare_field("sync_losses", oldest.sync_losses, out_data.sync_losses);
          compare_field("dropped_teeth", oldest.dropped_teeth, out_data.dropped_teeth);
        end
      end
      if (results_seen == 100 && !held_once) begin
        hold_left = 300;
        held_once = 1'b1;
      end
      if (hold_left != 0)
        hold_left--;
      else if (stall_left != 0)
        stall_left--;
      else if (!quiet && $urandom_range(0, 7) == 0)
        stall_left = $urandom_range(1, 15);
      out_stall <= (hold_left != 0) || (stall_left != 0);
    end
  end

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_PRIMARY_RISING:   cfg_m.primary_rising = val[0];
      CFG_SECONDARY_RISING: cfg_m.secondary_rising = val[0];
      CFG_MIN_PULSE_WIDTH:  cfg_m.min_pulse_width = val;
      CFG_MIN_ADVANCE:      cfg_m.min_advance = val;
      default: ;
    endcase
  endtask

  // Build a plausible edge event at now_ticks + gap; pin follows the current polarity
  task automatic queue_edge(input logic cam, input logic active, input logic [15:0] gap);
    in_req_t r;
    logic    pol;
    now_ticks = now_ticks + {16'd0, gap};
    pol = cam ? cfg_m.secondary_rising : cfg_m.primary_rising;
    r.req_type = cam ? REQ_SECONDARY : REQ_PRIMARY;
    r.pin_level = active ? pol : !pol;
    r.edge_time = now_ticks[15:0];
    r.overflow_pending = ($urandom_range(0, 3) == 0);
    // the extension word lags by one when the overflow is pending and edge_time[15] is clear
    r.ext_clock = now_ticks[31:16] -
                  ((r.overflow_pending && !r.edge_time[15]) ? 16'd1 : 16'd0);
    r.master_pulse_width = pick_word();
    r.injection_angle = pick_word();
    edge_q.push_back(r);
    events_queued++;
    if (active)
      active_queued++;
  endtask

  task automatic queue_noise();
    in_req_t r;
    r.req_type = 1'($urandom_range(0, 1));
    r.pin_level = 1'($urandom_range(0, 1));
    r.edge_time = 16'($urandom);
    r.ext_clock = 16'($urandom);
    r.overflow_pending = 1'($urandom_range(0, 1));
    r.master_pulse_width = 16'($urandom);
    r.injection_angle = 16'($urandom);
    edge_q.push_back(r);
    events_queued++;
    active_queued++;
  endtask

  task automatic queue_revolution(input int n_teeth);
    int spacing;
    spacing = ($urandom_range(0, 3) == 0) ? $urandom_range(5000, 9000)
                                           : $urandom_range(50, 3000);
    for (int i = 0; i < n_teeth; i++) begin
      if ($urandom_range(0, 9) == 0)
        queue_edge(REQ_PRIMARY, 1'b0, 16'($urandom_range(1, 40)));
      queue_edge(REQ_PRIMARY, 1'b1, 16'(spacing + $urandom_range(0, 60)));
    end
    if ($urandom_range(0, 9) == 0)
      queue_edge(REQ_SECONDARY, 1'b0, 16'($urandom_range(1, 40)));
    queue_edge(REQ_SECONDARY, 1'b1, 16'($urandom_range(1, spacing)));
  endtask

  task automatic wait_drain();
    while (results_seen < events_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input logic pr, input logic sr, input logic [15:0] min_pw,
                           input logic [15:0] min_adv, input int n_items);
    int first;
    write_cfg(CFG_PRIMARY_RISING, {15'd0, pr});
    write_cfg(CFG_SECONDARY_RISING, {15'd0, sr});
    write_cfg(CFG_MIN_PULSE_WIDTH, min_pw);
    write_cfg(CFG_MIN_ADVANCE, min_adv);
    first = active_queued;
    now_ticks = $urandom;
    while (active_queued - first < n_items) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: queue_revolution(TEETH);
        7: queue_revolution($urandom_range(0, TEETH + 4));
        8: repeat ($urandom_range(1, 5)) queue_noise();
        default: repeat ($urandom_range(1, 4))
                   queue_edge(1'($urandom_range(0, 1)), 1'b0, 16'($urandom));
      endcase
    end
    wait_drain();
  endtask

  initial begin
    cfg_m = '{primary_rising: 1'b1, secondary_rising: 1'b1,
              min_pulse_width: 16'd0, min_advance: 16'd0};
    m_teeth = '0;
    m_sync = 1'b0;
    m_latched = '0;
    m_last_tooth = '0;
    m_smooth = '0;
    m_last_cam = '0;
    m_period = '0;
    m_losses = '0;
    m_drops = '0;
    now_ticks = 32'h0000_7F00;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: ignored edges, a tooth before sync, a short count, then one tooth too many
    queue_edge(REQ_PRIMARY, 1'b0, 16'd10);
    queue_edge(REQ_SECONDARY, 1'b0, 16'd10);
    queue_edge(REQ_PRIMARY, 1'b1, 16'd100);
    queue_edge(REQ_SECONDARY, 1'b1, 16'd50);
    repeat (3) queue_edge(REQ_PRIMARY, 1'b1, 16'd700);
    queue_edge(REQ_SECONDARY, 1'b1, 16'd200);
    for (int i = 0; i < TEETH + 1; i++)
      queue_edge(REQ_PRIMARY, 1'b1, (i % 2 == 0) ? 16'hFFFF : 16'd1);
    wait_drain();

    // Long unsynced run so the tooth counter wraps, then a cam edge latches it
    repeat (270) queue_edge(REQ_PRIMARY, 1'b1, 16'($urandom_range(1, 2000)));
    queue_edge(REQ_SECONDARY, 1'b1, 16'd300);
    wait_drain();

    run_phase(1'b0, 1'b0, 16'h0000, 16'h0000, 130);
    run_phase(1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 130);
    run_phase(1'b0, 1'b1, 16'h1000, 16'h0800, 130);
    run_phase(1'b1, 1'b1, 16'h8000, 16'h0000, 130);
    quiet = 1'b1;
    run_phase(1'b1, 1'b1, 16'h0000, 16'h0400, 130);

    repeat (10) @(posedge clk);
    if (decoded_q.size() != 0) begin
      $display("%0t ns: %0d results missing, expected more, actual none",
               $time, decoded_q.size());
      errors++;
    end
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
